FILE: sv/rpms_pkg.sv
// Package for the residue packer and MinHash sketch.
// Holds sizes, hash constants, the residue code table, the command and status types.
// No dependencies.
`default_nettype none
package rpms_pkg;

  localparam int NUM_HASHES = 128;
  localparam int MAX_LENGTH = 65535;
  localparam int K_W        = $clog2(NUM_HASHES);
  localparam int ROWS       = (NUM_HASHES + 3) / 4;
  localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int WIN_W      = 25;

  localparam logic [31:0] SEED_MUL  = 32'h9e37_79b1;
  localparam logic [31:0] SEED_INIT = 32'h85eb_ca6b;
  localparam logic [31:0] MIX_MUL   = 32'h27d4_eb2d;
  localparam logic [31:0] MIX_XOR   = 32'd61;
  localparam logic [15:0] LEN_MAX   = 16'(MAX_LENGTH);

  localparam logic KIND_PLANE = 1'b0;
  localparam logic KIND_SIG   = 1'b1;

  typedef enum logic [2:0] {
    B_IDLE,
    B_HASH,
    B_DRAIN,
    B_PLANE,
    B_SIG_RD,
    B_SIG_OUT
  } bstate_t;

  typedef struct packed {
    logic              do_hash;
    logic [WIN_W-1:0]  window;
    logic              plane_emit;
    logic [3:0][31:0]  planes;
    logic [10:0]       plane_blk;
    logic [15:0]       length;
    logic              too_long;
    logic              seq_end;
  } cmd_t;

  typedef struct packed {
    bstate_t state;
    logic    hash_active;
  } bstat_t;

  // Case-folded residue letter to 4-bit code.
  function automatic logic [3:0] code_of(input logic [7:0] ch);
    logic [7:0] u;
    u = (ch >= 8'h61 && ch <= 8'h7a) ? ch - 8'h20 : ch;
    unique case (u)
      "A": code_of = 4'd1;
      "C": code_of = 4'd2;
      "D": code_of = 4'd3;
      "E": code_of = 4'd4;
      "F": code_of = 4'd5;
      "G": code_of = 4'd6;
      "H": code_of = 4'd7;
      "I": code_of = 4'd8;
      "K": code_of = 4'd9;
      "L": code_of = 4'd10;
      "M": code_of = 4'd10;
      "N": code_of = 4'd11;
      "P": code_of = 4'd12;
      "Q": code_of = 4'd4;
      "R": code_of = 4'd13;
      "S": code_of = 4'd14;
      "T": code_of = 4'd15;
      "V": code_of = 4'd8;
      "W": code_of = 4'd5;
      "Y": code_of = 4'd5;
      default: code_of = 4'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

FILE: sv/rpms_if.sv
// Valid/ready channel interfaces for residue input and result output.
// Depends on nothing.
`default_nettype none
interface rpms_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] residue;
  logic       end_of_sequence;
  logic       no_residue;
  modport source (output valid, residue, end_of_sequence, no_residue, input ready);
  modport sink   (input valid, residue, end_of_sequence, no_residue, output ready);
endinterface

interface rpms_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] word0;
  logic [31:0] word1;
  logic [31:0] word2;
  logic [31:0] word3;
  logic [10:0] block_index;
  logic [15:0] sequence_length;
  logic        too_long;
  logic        last_result;
  modport source (output valid, kind, word0, word1, word2, word3, block_index,
                  sequence_length, too_long, last_result, input ready);
  modport sink   (input valid, kind, word0, word1, word2, word3, block_index,
                  sequence_length, too_long, last_result, output ready);
endinterface
`default_nettype wire

FILE: sv/rpms_front.sv
// Front end: accepts residues, packs bit planes, keeps the k-mer window and length.
// Depends on rpms_pkg and rpms_in_if; issues cmd_t commands to the queue.
`default_nettype none
module rpms_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  rpms_in_if.sink            in_ch,
  input  wire logic          q_full,
  output logic               q_push,
  output rpms_pkg::cmd_t     q_data
);
  import rpms_pkg::*;

  logic [15:0]       cnt_r, cnt_nxt;
  logic [3:0][31:0]  planes_r, planes_nxt;
  logic [WIN_W-1:0]  win_r, win_nxt;

  logic              fire, take, is_end, full_grp, part_grp;
  logic [3:0]        code;
  logic [15:0]       cnt_new, cnt_m1;
  logic [3:0][31:0]  planes_new;
  logic [WIN_W-1:0]  win_new;

  assign in_ch.ready = !q_full;
  assign fire        = in_ch.valid && in_ch.ready;

  always_comb begin
    is_end  = in_ch.end_of_sequence;
    take    = !in_ch.no_residue && (cnt_r != LEN_MAX);
    code    = code_of(in_ch.residue);
    planes_new = planes_r;
    win_new    = win_r;
    cnt_new    = cnt_r;
    if (take) begin
      for (int e = 0; e < 4; e++) begin
        planes_new[e][cnt_r[4:0]] = code[e];
      end
      win_new = {win_r[WIN_W-5:0], code};
      cnt_new = cnt_r + 16'd1;
    end
    cnt_m1   = cnt_new - 16'd1;
    full_grp = take && (cnt_new[4:0] == 5'd0);
    part_grp = is_end && (cnt_new[4:0] != 5'd0);

    q_data.do_hash    = take && (cnt_r >= 16'd6 || is_end);
    q_data.window     = win_new;
    q_data.plane_emit = full_grp || part_grp;
    q_data.planes     = planes_new;
    q_data.plane_blk  = cnt_m1[15:5];
    q_data.length     = cnt_new;
    q_data.too_long   = (cnt_new == LEN_MAX);
    q_data.seq_end    = is_end;

    // a stray no-residue item without a close does nothing
    q_push = fire && (q_data.do_hash || q_data.plane_emit || is_end);

    cnt_nxt    = cnt_r;
    planes_nxt = planes_r;
    win_nxt    = win_r;
    if (fire && !(in_ch.no_residue && !is_end)) begin
      cnt_nxt    = cnt_new;
      planes_nxt = full_grp ? '0 : planes_new;
      win_nxt    = win_new;
      if (is_end) begin
        cnt_nxt    = '0;
        planes_nxt = '0;
        win_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      planes_r <= '0;
      win_r    <= '0;
    end else begin
      cnt_r    <= cnt_nxt;
      planes_r <= planes_nxt;
      win_r    <= win_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/rpms_fifo.sv
// Two-entry command queue between front and back ends.
// Depends on rpms_pkg for cmd_t.
`default_nettype none
module rpms_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire rpms_pkg::cmd_t push_data,
  output logic                full,
  input  wire logic           pop,
  output rpms_pkg::cmd_t      pop_data,
  output logic                empty
);
  import rpms_pkg::*;

  cmd_t       mem [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) wp_r <= !wp_r;
      if (pop && !empty) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule
`default_nettype wire

FILE: sv/rpms_hash.sv
// Four-stage pipelined seeded Wang hash, one seed per cycle.
// Depends on rpms_pkg for constants.
`default_nettype none
module rpms_hash (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_vld,
  input  wire logic [rpms_pkg::WIN_W-1:0] win,
  input  wire logic [31:0]               seed,
  input  wire logic [rpms_pkg::K_W-1:0]  in_idx,
  output logic                           s2_vld,
  output logic [rpms_pkg::K_W-1:0]       s2_idx,
  output logic                           out_vld,
  output logic [rpms_pkg::K_W-1:0]       out_idx,
  output logic [31:0]                    out_hash,
  output logic                           busy
);
  import rpms_pkg::*;

  logic [3:0]       vld_r;
  logic [K_W-1:0]   idx_r [4];
  logic [31:0]      v0_r, v1_r, v2_r, v3_r;
  logic [31:0]      a, b, c, d;

  always_comb begin
    a = {{(32-WIN_W){1'b0}}, win} ^ seed;
    b = (a ^ MIX_XOR) ^ (a >> 16);
    c = b + (b << 3);
    d = c ^ (c >> 4);
  end

  always_ff @(posedge clk) begin
    v0_r <= d;
    v1_r <= v0_r * MIX_MUL;
    v2_r <= (v1_r ^ (v1_r >> 15)) ^ ((v1_r ^ (v1_r >> 15)) >> 8);
    v3_r <= v2_r * SEED_MUL;
    idx_r[0] <= in_idx;
    idx_r[1] <= idx_r[0];
    idx_r[2] <= idx_r[1];
    idx_r[3] <= idx_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  assign s2_vld   = vld_r[2];
  assign s2_idx   = idx_r[2];
  assign out_vld  = vld_r[3];
  assign out_idx  = idx_r[3];
  assign out_hash = v3_r ^ (v3_r >> 14);
  assign busy     = |vld_r;

endmodule
`default_nettype wire

FILE: sv/rpms_back.sv
// Back end: hash sweeps over the signature store, plane and signature result output.
// Depends on rpms_pkg, rpms_out_if and rpms_hash.
`default_nettype none
module rpms_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  input  wire rpms_pkg::cmd_t q_data,
  output logic                q_pop,
  rpms_out_if.source          out_ch,
  output rpms_pkg::bstat_t    stat
);
  import rpms_pkg::*;

  bstate_t          state_r, state_nxt;
  cmd_t             cur_r;
  logic [K_W-1:0]   k_r;
  logic [31:0]      seed_r;
  logic [ROW_W-1:0] b_r;

  logic             out_vld_r;
  logic             kind_r, too_long_r, last_r;
  logic [3:0][31:0] words_r;
  logic [10:0]      blk_r;
  logic [15:0]      len_r;

  logic             issue, ld_plane, ld_sig, clr_val, out_free, last_blk;
  logic             h_s2_vld, h_out_vld, h_busy;
  logic [K_W-1:0]   h_s2_idx, h_out_idx;
  logic [31:0]      h_out;

  logic [ROWS*4-1:0] val_r;
  logic [31:0]       rd_r [4];
  logic              rd_val_r [4];
  logic              rd_en;
  logic [ROW_W-1:0]  rd_row;
  logic [31:0]       rd_eff [4];
  logic [3:0][31:0]  sig_w;

  assign out_free = !out_vld_r || out_ch.ready;
  assign last_blk = (b_r == ROW_W'(ROWS - 1));

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    issue     = 1'b0;
    ld_plane  = 1'b0;
    ld_sig    = 1'b0;
    clr_val   = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          priority if (q_data.do_hash) state_nxt = B_HASH;
          else if (q_data.plane_emit)  state_nxt = B_PLANE;
          else if (q_data.seq_end)     state_nxt = B_SIG_RD;
          else                         state_nxt = B_IDLE;
        end
      end
      B_HASH: begin
        issue = 1'b1;
        if (k_r == K_W'(NUM_HASHES - 1)) state_nxt = B_DRAIN;
      end
      B_DRAIN: begin
        if (!h_busy) begin
          priority if (cur_r.plane_emit) state_nxt = B_PLANE;
          else if (cur_r.seq_end)        state_nxt = B_SIG_RD;
          else                           state_nxt = B_IDLE;
        end
      end
      B_PLANE: begin
        if (out_free) begin
          ld_plane  = 1'b1;
          state_nxt = cur_r.seq_end ? B_SIG_RD : B_IDLE;
        end
      end
      B_SIG_RD: begin
        state_nxt = B_SIG_OUT;
      end
      B_SIG_OUT: begin
        if (out_free) begin
          ld_sig = 1'b1;
          if (last_blk) begin
            clr_val   = 1'b1;
            state_nxt = B_IDLE;
          end else begin
            state_nxt = B_SIG_RD;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  rpms_hash u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (issue),
    .win      (cur_r.window),
    .seed     (seed_r),
    .in_idx   (k_r),
    .s2_vld   (h_s2_vld),
    .s2_idx   (h_s2_idx),
    .out_vld  (h_out_vld),
    .out_idx  (h_out_idx),
    .out_hash (h_out),
    .busy     (h_busy)
  );

  // read one row of all four banks: for the hash compare or for a signature block
  assign rd_en  = h_s2_vld || (state_r == B_SIG_RD);
  assign rd_row = h_s2_vld ? ROW_W'(h_s2_idx >> 2) : b_r;

  for (genvar g = 0; g < 4; g++) begin : g_bank
    logic [31:0] bank [ROWS];
    logic        wr;
    logic [31:0] wdata;
    assign rd_eff[g] = rd_val_r[g] ? rd_r[g] : 32'hffff_ffff;
    assign wr        = h_out_vld && (h_out_idx[1:0] == 2'(g));
    assign wdata     = (h_out < rd_eff[g]) ? h_out : rd_eff[g];
    assign sig_w[g]  = ((32'(b_r) * 32'd4 + 32'(g)) < 32'(NUM_HASHES)) ? rd_eff[g] : 32'd0;
    always_ff @(posedge clk) begin
      if (wr) bank[ROW_W'(h_out_idx >> 2)] <= wdata;
      if (rd_en) begin
        rd_r[g]     <= bank[rd_row];
        rd_val_r[g] <= val_r[{rd_row, 2'(g)}];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else if (clr_val) begin
      val_r <= '0;
    end else if (h_out_vld) begin
      val_r[h_out_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      out_vld_r <= 1'b0;
      k_r       <= '0;
      seed_r    <= SEED_INIT;
      b_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        k_r    <= '0;
        seed_r <= SEED_INIT;
        b_r    <= '0;
      end
      if (issue) begin
        k_r    <= k_r + K_W'(1);
        seed_r <= seed_r + SEED_MUL;
      end
      if (ld_sig) b_r <= last_blk ? '0 : b_r + ROW_W'(1);
      if (ld_plane || ld_sig)  out_vld_r <= 1'b1;
      else if (out_ch.ready)   out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_data;
    if (ld_plane) begin
      kind_r  <= KIND_PLANE;
      words_r <= cur_r.planes;
      blk_r   <= cur_r.plane_blk;
      last_r  <= 1'b0;
    end
    if (ld_sig) begin
      kind_r  <= KIND_SIG;
      words_r <= sig_w;
      blk_r   <= 11'(b_r);
      last_r  <= last_blk;
    end
    if (ld_plane || ld_sig) begin
      len_r      <= cur_r.length;
      too_long_r <= cur_r.too_long;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.kind            = kind_r;
  assign out_ch.word0           = words_r[0];
  assign out_ch.word1           = words_r[1];
  assign out_ch.word2           = words_r[2];
  assign out_ch.word3           = words_r[3];
  assign out_ch.block_index     = blk_r;
  assign out_ch.sequence_length = len_r;
  assign out_ch.too_long        = too_long_r;
  assign out_ch.last_result     = last_r;

  assign stat.state       = state_r;
  assign stat.hash_active = h_busy;

endmodule
`default_nettype wire

FILE: sv/residue_pack_minhash_sketch.sv
// Top level of the residue packer and MinHash k-mer sketch.
// Depends on rpms_pkg, rpms_if, rpms_front, rpms_fifo, rpms_hash and rpms_back.
//
//  channel | direction | payload
//  --------+-----------+---------------------------------------------------------
//  in_ch   | sink      | residue, end_of_sequence, no_residue
//  out_ch  | source    | kind, word0..3, block_index, sequence_length, too_long,
//          |           | last_result
//
// A hashed residue occupies the back end while it pops the command, issues one seed per
// cycle through the four-stage hash unit and then drains it; the hash unit sets the rate.
// Unhashed residues that complete no plane group need no command; a close adds a read
// state and an output state per signature block. Reset is synchronous, active low; the
// store reads all ones after it.
// The front end stalls only when the two-entry queue is full; the back end stalls
// only on a held output transfer.
`default_nettype none
module residue_pack_minhash_sketch (
  input  wire logic clk,
  input  wire logic rst_n,
  rpms_in_if.sink   in_ch,
  rpms_out_if.source out_ch
);
  import rpms_pkg::*;

  cmd_t   q_wdata, q_rdata;
  logic   q_push, q_full, q_pop, q_empty;
  bstat_t stat;

  // front: classify and pack, hand off one command per item that needs work
  rpms_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  rpms_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // back: hash sweep, then plane group, then signature blocks
  rpms_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch),
    .stat    (stat)
  );

`ifndef SYNTHESIS
  a_plane_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.kind == KIND_PLANE) |-> !out_ch.last_result)
    else $error("plane group flagged as last result");

  a_last_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last_result |-> out_ch.block_index == 11'(ROWS - 1))
    else $error("last signature block has wrong index");

  a_hash_phase: assert property (@(posedge clk) disable iff (!rst_n)
    stat.hash_active |-> (stat.state == B_HASH) || (stat.state == B_DRAIN))
    else $error("hash unit active outside a sweep");
`endif

endmodule
`default_nettype wire

FILE: bench/rpms_tb_if.sv
// Bench package: the packed result record used by the predictor and the checker.
// Channel interfaces come from sv/rpms_if.sv; depends on rpms_pkg.
`timescale 1ns / 1ps
package rpms_tb_pkg;
  import rpms_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] word3;
    logic [10:0] block_index;
    logic [15:0] sequence_length;
    logic        too_long;
    logic        last_result;
  } sketch_result_t;
endpackage

FILE: bench/testbench.sv
// Self-checking bench for residue_pack_minhash_sketch.
// Drives residue transfers, predicts plane groups and signature blocks in-line,
// and compares each output transfer; depends on rpms_pkg, rpms_if and rpms_tb_pkg.
`timescale 1ns / 1ps
module testbench;
  import rpms_pkg::*;
  import rpms_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rpms_in_if  in_ch ();
  rpms_out_if out_ch ();

  residue_pack_minhash_sketch u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state: own copy of window, planes, count and minimums
  logic [WIN_W-1:0] win_q;
  logic [31:0]      planes_q [4];
  logic [15:0]      count_q;
  logic [31:0]      mins_q [NUM_HASHES];

  sketch_result_t expected_q [$];
  int  mismatches = 0;
  int  results_seen = 0;
  int  transfers_sent = 0;
  int  cycles = 0;
  bit  calm = 1'b0;  // when set, neither side idles

  // Map a residue letter to its code, ignoring case
  function automatic logic [3:0] letter_code(input logic [7:0] ch);
    logic [7:0] u;
    u = (ch >= 8'h61 && ch <= 8'h7a) ? ch - 8'h20 : ch;
    unique case (u)
      8'h41: return 4'd1;   8'h43: return 4'd2;   8'h44: return 4'd3;
      8'h45: return 4'd4;   8'h46: return 4'd5;   8'h47: return 4'd6;
      8'h48: return 4'd7;   8'h49: return 4'd8;   8'h4b: return 4'd9;
      8'h4c: return 4'd10;  8'h4d: return 4'd10;  8'h4e: return 4'd11;
      8'h50: return 4'd12;  8'h51: return 4'd4;   8'h52: return 4'd13;
      8'h53: return 4'd14;  8'h54: return 4'd15;  8'h56: return 4'd8;
      8'h57: return 4'd5;   8'h59: return 4'd5;
      default: return 4'd0;
    endcase
  endfunction

  function automatic logic [31:0] wang_mix(input logic [31:0] v_in, input logic [31:0] seed);
    logic [31:0] v;
    v = v_in ^ seed;
    v = (v ^ MIX_XOR) ^ (v >> 16);
    v = v + (v << 3);
    v = v ^ (v >> 4);
    v = v * MIX_MUL;
    v = v ^ (v >> 15);
    v = (v ^ (v >> 8)) * SEED_MUL;
    return v ^ (v >> 14);
  endfunction

  task automatic clear_sketch();
    win_q = '0;
    count_q = '0;
    for (int e = 0; e < 4; e++) planes_q[e] = '0;
    for (int k = 0; k < NUM_HASHES; k++) mins_q[k] = '1;
  endtask

  function automatic sketch_result_t make_result(input logic kind, input logic [31:0] w0,
      input logic [31:0] w1, input logic [31:0] w2, input logic [31:0] w3,
      input logic [10:0] blk, input logic last);
    sketch_result_t r;
    r.kind = kind; r.word0 = w0; r.word1 = w1; r.word2 = w2; r.word3 = w3;
    r.block_index = blk;
    r.sequence_length = count_q;
    r.too_long = (count_q == LEN_MAX);
    r.last_result = last;
    return r;
  endfunction

  // Append one expectation at the tail of the queue
  task automatic expect_result(input sketch_result_t r);
    expected_q = {expected_q, r};
  endtask

  // Work out the results caused by one accepted input transfer
  task automatic predict_sketch(input logic [7:0] ch, input logic eos, input logic none);
    logic [3:0]  code;
    logic [15:0] idx;
    logic [31:0] seed, h;
    logic [31:0] w [4];
    if (none && !eos) return;
    if (!none && count_q != LEN_MAX) begin
      idx = count_q;
      code = letter_code(ch);
      for (int e = 0; e < 4; e++) planes_q[e][idx[4:0]] = code[e];
      win_q = {win_q[WIN_W-5:0], 4'b0} + code;
      if (idx >= 6 || eos) begin
        for (int k = 0; k < NUM_HASHES; k++) begin
          seed = 32'(k) * SEED_MUL + SEED_INIT;
          h = wang_mix(32'(win_q), seed);
          if (h < mins_q[k]) mins_q[k] = h;
        end
      end
      count_q = idx + 16'd1;
      if (count_q[4:0] == 5'd0) begin
        expect_result(make_result(KIND_PLANE, planes_q[0], planes_q[1],
                      planes_q[2], planes_q[3], 11'(idx >> 5), 1'b0));
        for (int e = 0; e < 4; e++) planes_q[e] = '0;
      end
    end
    if (eos) begin
      if (count_q[4:0] != 5'd0)
        expect_result(make_result(KIND_PLANE, planes_q[0], planes_q[1],
                      planes_q[2], planes_q[3], 11'((count_q - 16'd1) >> 5), 1'b0));
      for (int b = 0; b < ROWS; b++) begin
        for (int e = 0; e < 4; e++)
          w[e] = (b * 4 + e < NUM_HASHES) ? mins_q[b * 4 + e] : 32'd0;
        expect_result(make_result(KIND_SIG, w[0], w[1], w[2], w[3], 11'(b),
                      b == ROWS - 1));
      end
      clear_sketch();
    end
  endtask

  // Send one input transfer; random idle cycles before it, valid held until accepted
  task automatic send_residue(input logic [7:0] ch, input logic eos, input logic none);
    while (!calm && $urandom_range(99, 0) < 21) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.residue <= ch;
    in_ch.end_of_sequence <= eos;
    in_ch.no_residue <= none;
    do @(posedge clk); while (!in_ch.ready);
    predict_sketch(ch, eos, none);
    transfers_sent++;
    @(negedge clk);
  endtask

  // Random output stalls, re-drawn each falling edge
  always @(negedge clk) begin
    if (rst_n) out_ch.ready <= calm ? 1'b1 : ($urandom_range(99, 0) >= 21);
  end

  // Check each output transfer against the oldest expectation
  always @(posedge clk) begin
    sketch_result_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.kind, out_ch.word0, out_ch.word1, out_ch.word2, out_ch.word3,
              out_ch.block_index, out_ch.sequence_length, out_ch.too_long,
              out_ch.last_result};
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch:\n  expected %p\n  actual   %p", want, got);
        end
      end
    end
  end

  // Hold a generous cycle budget: about 115 transfers, each of which may run a full hash sweep, plus stalls
  always @(posedge clk) begin
    cycles++;
    if (cycles > 1_000_000) begin
      $display("timeout with %0d results outstanding", expected_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_letters(input string s, input logic close);
    for (int i = 0; i < s.len(); i++)
      send_residue(s[i], close && i == s.len() - 1, 1'b0);
  endtask

  // Every letter, both cases, plus extreme bytes
  task automatic test_letter_codes();
    send_letters("ACDEFGHIKLMNPQRSTVWY", 1'b0);
    send_letters("acdefghiklmnpqrstvwyBxz", 1'b0);
    send_residue(8'h00, 1'b0, 1'b0);
    send_residue(8'hff, 1'b1, 1'b0);
  endtask

  // Empty close, stray no-residue, short sequence, close by no-residue, single-residue close
  task automatic test_closes();
    send_residue(8'h41, 1'b1, 1'b1);
    send_residue(8'hff, 1'b0, 1'b1);
    send_letters("MKV", 1'b1);
    send_letters("WWYYHHPPQ", 1'b0);
    send_residue(8'h00, 1'b1, 1'b1);
    send_residue(8'h5a, 1'b1, 1'b0);
  endtask

  task automatic test_random_sequences();
    string alpha;
    int len;
    logic [7:0] ch;
    alpha = "ACDEFGHIKLMNPQRSTVWYacdefghiklmnpqrstvwy";
    for (int s = 0; s < 5; s++) begin
      calm = (s == 2);
      len = (s == 2) ? 33 : $urandom_range(6, 1);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(9, 0) == 0) ch = 8'($urandom);
        else ch = alpha[$urandom_range(alpha.len() - 1, 0)];
        if ($urandom_range(19, 0) == 0) send_residue(8'($urandom), 1'b0, 1'b1);
        send_residue(ch, i == len - 1 && $urandom_range(3, 0) != 0, 1'b0);
      end
      send_residue(8'($urandom), 1'b1, 1'b1);
    end
    calm = 1'b0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.residue = '0;
    in_ch.end_of_sequence = 1'b0;
    in_ch.no_residue = 1'b0;
    out_ch.ready = 1'b0;
    clear_sketch();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_letter_codes();
    test_closes();
    test_random_sequences();
    in_ch.valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("sent %0d residue transfers over all codes, closes and random sequences",
             transfers_sent);
    $display("checked %0d plane and signature results", results_seen);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
